FILE: sv/assert_macros.svh
// Assertion macros used by the checker file spq_checker.sv.
// No dependencies; the including module must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds across reset.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: sv/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// No dependencies.
package spq_pkg;

  localparam int unsigned SPQ_DEFAULT_CAPACITY = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 5;

  // Operation codes
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } spq_status_e;

  // One slot of the chain.
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] prio;
  } spq_entry_t;

  // Command broadcast to every cell; ins and del already qualified.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] prio;
  } spq_cmd_t;

endpackage

FILE: sv/spq_cell.sv
// One slot of the sorted chain: holds an entry, shifts towards the tail on
// insert and towards the head on removal. Depends on spq_pkg.
module spq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::spq_cmd_t   cmd_i,
  input  spq_pkg::spq_entry_t left_i,   // neighbour nearer the head
  input  spq_pkg::spq_entry_t right_i,  // neighbour nearer the tail
  input  logic                take_i,   // insert point lies at or before left
  input  logic                hit_i,    // removal point lies before this cell
  output logic                take_o,
  output logic                hit_o,
  output logic                sel_o,    // this cell is the first match
  output spq_pkg::spq_entry_t entry_o
);
  import spq_pkg::*;

  logic              valid_q, valid_d;
  logic [DATA_W-1:0] value_q, value_d;
  logic [DATA_W-1:0] prio_q, prio_d;
  logic              match;

  // Empty slots count as "greater or equal" so the insert lands at the tail.
  assign take_o = !valid_q || ($signed(prio_q) >= $signed(cmd_i.prio));
  assign match  = cmd_i.del && valid_q && (value_q == cmd_i.value);
  assign hit_o  = hit_i || match;
  assign sel_o  = match && !hit_i;

  assign entry_o = '{valid: valid_q, value: value_q, prio: prio_q};

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    prio_d  = prio_q;
    if (cmd_i.ins) begin
      if (take_i) begin
        valid_d = left_i.valid;
        value_d = left_i.value;
        prio_d  = left_i.prio;
      end else if (take_o) begin
        valid_d = 1'b1;
        value_d = cmd_i.value;
        prio_d  = cmd_i.prio;
      end
    end else if (hit_o) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
      prio_d  = right_i.prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

endmodule

FILE: sv/sorted_priority_queue.sv
// Sorted priority queue: top level, a chain of spq_cell slots plus the
// result register. Depends on spq_pkg and spq_cell.
//
//  channel | valid      | stall        | payload
//  --------+------------+--------------+--------------------------------------
//  in      | in_valid_i | in_stall_o   | kind_i, value_i, priority_req_i
//  out     | out_valid_o| out_stall_i  | status_o, out_value_o,
//          |            |              | out_priority_o, occupancy_o
//
// Every operation completes at the edge that accepts the transfer: the whole
// chain updates at that edge and the result appears in the next cycle.
// A new transfer is taken every cycle unless a result is held under stall.
// Reset clears the slot valid bits, the count and the result valid flag.
// Search ripples one bit per slot; each insert-point bit is a local compare.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::SPQ_DEFAULT_CAPACITY
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       kind_i,
  input  logic signed [spq_pkg::DATA_W-1:0] value_i,
  input  logic signed [spq_pkg::DATA_W-1:0] priority_req_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic signed [spq_pkg::DATA_W-1:0] out_value_o,
  output logic signed [spq_pkg::DATA_W-1:0] out_priority_o,
  output logic [spq_pkg::OCC_W-1:0]         occupancy_o
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic                 accept;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 full, empty;
  spq_cmd_t             cmd;

  // Chain wiring; index i feeds cell i, index i+1 comes out of it.
  logic       take_chain [CAPACITY+1];
  logic       hit_chain  [CAPACITY+1];
  logic       sel        [CAPACITY];
  spq_entry_t entries    [CAPACITY];

  logic              found;
  logic [DATA_W-1:0] found_value, found_prio;

  logic              out_valid_q, out_valid_d;
  spq_status_e       status_q, status_d;
  logic [DATA_W-1:0] value_q, value_d;
  logic [DATA_W-1:0] prio_q, prio_d;
  logic [OCC_W-1:0]  occ_q, occ_d;
  logic [CNT_W+OCC_W-1:0] count_ext;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  // Only accepted operations reach the cells; an insert only when not full.
  assign cmd.ins   = accept && (kind_i == KIND_INSERT) && !full;
  assign cmd.del   = accept && (kind_i == KIND_DELETE);
  assign cmd.value = value_i;
  assign cmd.prio  = priority_req_i;

  // A pop is a removal at the head: every cell shifts one place forward.
  assign take_chain[0] = 1'b0;
  assign hit_chain[0]  = accept && (kind_i == KIND_POP) && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_entry_t left, right;
    if (i == 0) begin : g_head
      assign left = '0;
    end else begin : g_mid
      assign left = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .take_i  (take_chain[i]),
      .hit_i   (hit_chain[i]),
      .take_o  (take_chain[i+1]),
      .hit_o   (hit_chain[i+1]),
      .sel_o   (sel[i]),
      .entry_o (entries[i])
    );
  end

  // At most one cell flags the first match, so an OR picks its contents.
  always_comb begin
    found       = 1'b0;
    found_value = '0;
    found_prio  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found       = found | sel[i];
      found_value = found_value | (entries[i].value & {DATA_W{sel[i]}});
      found_prio  = found_prio  | (entries[i].prio  & {DATA_W{sel[i]}});
    end
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    value_d  = '0;
    prio_d   = '0;
    case (kind_i)
      KIND_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      KIND_POP: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          value_d = entries[0].value;
          prio_d  = entries[0].prio;
          count_d = count_q - CNT_W'(1);
        end
      end
      KIND_DELETE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (!found) begin
          status_d = ST_NOT_FOUND;
        end else begin
          value_d = found_value;
          prio_d  = found_prio;
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
        // unused code: no change, plain ok
      end
    endcase
  end

  // Occupancy field carries the count modulo 32.
  assign count_ext = (CNT_W+OCC_W)'(count_d);
  assign occ_d     = count_ext[OCC_W-1:0];

  assign out_valid_d = accept ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      value_q  <= value_d;
      prio_q   <= prio_d;
      occ_q    <= occ_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_value_o    = value_q;
  assign out_priority_o = prio_q;
  assign occupancy_o    = occ_q;

endmodule

FILE: sv/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spq_checker #(
  parameter int unsigned CAPACITY = spq_pkg::SPQ_DEFAULT_CAPACITY
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [1:0]                  kind_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  status_o,
  input logic [spq_pkg::DATA_W-1:0]  out_value_o,
  input logic [spq_pkg::DATA_W-1:0]  out_priority_o,
  input logic [spq_pkg::OCC_W-1:0]   occupancy_o
);
  import spq_pkg::*;

  localparam logic [OCC_W-1:0] CAP_OCC = OCC_W'(CAPACITY);

  `SPQ_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped under stall")
  `SPQ_ASSERT(a_accept_result, in_valid_i && !in_stall_o |=> out_valid_o, "transfer gave no result")
  `SPQ_ASSERT(a_full_occ, out_valid_o && status_o == ST_FULL |-> occupancy_o == CAP_OCC, "full but occupancy off")
  `SPQ_ASSERT(a_empty_zero, out_valid_o && status_o == ST_EMPTY |-> occupancy_o == '0 && out_value_o == '0 && out_priority_o == '0, "empty result not cleared")
  `SPQ_ASSERT(a_miss_zero, out_valid_o && (status_o == ST_NOT_FOUND || kind_i == kind_i && status_o == ST_FULL) |-> out_value_o == '0 && out_priority_o == '0, "failed op returned data")

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .kind_i         (kind_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .out_value_o    (out_value_o),
  .out_priority_o (out_priority_o),
  .occupancy_o    (occupancy_o)
);
